>>> hw/rtl/cts_pkg.sv
// Shared types, constants and helper functions for the cyclic time-slot scheduler.
package cts_pkg;

   // Table geometry and field widths.
   localparam int MAX_SLOTS  = 32;
   localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
   localparam int COUNT_BITS = SLOT_BITS + 1;
   localparam int OWNER_BITS = 8;
   localparam int DUR_BITS   = 32;
   localparam int TIME_BITS  = 64;

   // Stream beat layout, lowest bit first.
   localparam int IN_OP_BITS    = 2;
   localparam int IN_DATA_BITS  = 112;
   localparam int OUT_DATA_BITS = 144;

   // Configuration register file.
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam bit REG_SLOT_COUNT   = 1'b0;
   localparam bit REG_FRAME_LENGTH = 1'b1;
   localparam logic [COUNT_BITS-1:0] SLOT_COUNT_RESET = COUNT_BITS'(1);

   // Operation carried in the input beat's tuser.
   typedef enum logic [IN_OP_BITS-1:0] {
      OP_WRITE   = 2'd0,
      OP_RESTART = 2'd1,
      OP_TICK    = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   // One slot table entry.
   typedef struct packed {
      logic [DUR_BITS-1:0]   duration;
      logic [OWNER_BITS-1:0] owner;
      logic                  periodic;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic table_write;
      logic restart_start;
      logic tick_start;
      logic walk_start;
      logic restart_apply;
      logic tick_apply;
      logic walk_step;
      logic result_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   tick_due;
      logic   walk_hit;
      logic   walk_last;
   } status_type;

   // Number of slots in use: zero acts as one, large values clip to the table size.
   function automatic logic [COUNT_BITS-1:0] used_count(input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS-1:0] result;
      if (count == '0) begin
         result = COUNT_BITS'(1);
      end else if (count > COUNT_BITS'(MAX_SLOTS)) begin
         result = COUNT_BITS'(MAX_SLOTS);
      end else begin
         result = count;
      end
      return result;
   endfunction

   // True when the slot after the given one falls at or beyond the slot count.
   function automatic logic slot_wraps(input logic [SLOT_BITS-1:0] slot,
                                       input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS-1:0] next;
      next = {1'b0, slot} + COUNT_BITS'(1);
      return (next >= count);
   endfunction

   // Slot that follows the given one, wrapping to slot 0.
   function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] slot,
                                                      input logic [COUNT_BITS-1:0] count);
      logic [SLOT_BITS-1:0] result;
      if (slot_wraps(slot, count)) begin
         result = '0;
      end else begin
         result = slot + SLOT_BITS'(1);
      end
      return result;
   endfunction

endpackage

>>> hw/rtl/cts_ctrl.sv
// Controller state machine that sequences each operation of the slot scheduler.
module cts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  cts_pkg::status_type status,
   output cts_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_APPLY,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      load;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // The result register may be loaded when it is empty or being drained.
   assign load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // Commands and next state.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op)
               cts_pkg::OP_WRITE: begin
                  cmd.table_write = 1'b1;
                  state_in        = ST_FINISH;
               end
               cts_pkg::OP_RESTART: begin
                  cmd.restart_start = 1'b1;
                  state_in          = ST_APPLY;
               end
               cts_pkg::OP_TICK: begin
                  cmd.tick_start = status.tick_due;
                  state_in       = status.tick_due ? ST_APPLY : ST_FINISH;
               end
               cts_pkg::OP_QUERY: begin
                  cmd.walk_start = 1'b1;
                  state_in       = ST_WALK;
               end
            endcase
         end
         ST_APPLY: begin
            cmd.restart_apply = (status.op == cts_pkg::OP_RESTART);
            cmd.tick_apply    = (status.op != cts_pkg::OP_RESTART);
            state_in          = ST_FINISH;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_hit || status.walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.result_load = load;
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid flag follows loads and drains.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/cts_dp.sv
// Datapath of the slot scheduler: slot table, schedule state, window walk and result register.
module cts_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cts_pkg::op_type                          in_operation,
   input  logic [cts_pkg::TIME_BITS-1:0]            in_now,
   input  logic [cts_pkg::SLOT_BITS-1:0]            in_slot_index,
   input  logic [cts_pkg::DUR_BITS-1:0]             in_slot_length,
   input  logic [cts_pkg::OWNER_BITS-1:0]           in_slot_owner,
   input  logic                                     in_slot_periodic,
   input  logic [cts_pkg::COUNT_BITS-1:0]           slot_count_used,
   input  logic [cts_pkg::DUR_BITS-1:0]             frame_length,
   input  cts_pkg::cmd_type                         cmd,
   output cts_pkg::status_type                      status,
   output logic [cts_pkg::OWNER_BITS-1:0]           out_owner,
   output logic                                     out_switched,
   output logic [cts_pkg::SLOT_BITS-1:0]            out_slot,
   output logic [cts_pkg::TIME_BITS-1:0]            out_deadline,
   output logic [cts_pkg::TIME_BITS-1:0]            out_window_start,
   output logic                                     out_window_found
);

   // Captured input beat.
   cts_pkg::op_type                     op_ff;
   logic [cts_pkg::TIME_BITS-1:0]       now_ff;
   logic [cts_pkg::SLOT_BITS-1:0]       index_ff;
   cts_pkg::entry_type                  wr_entry_ff;

   // Slot table with registered read port.
   cts_pkg::entry_type                  table_mem [cts_pkg::MAX_SLOTS];
   cts_pkg::entry_type                  rd_entry_ff;
   logic                                rd_en;
   logic [cts_pkg::SLOT_BITS-1:0]       rd_addr;

   // Schedule state.
   logic [cts_pkg::SLOT_BITS-1:0]       cur_slot_ff;
   logic [cts_pkg::OWNER_BITS-1:0]      cur_owner_ff;
   logic [cts_pkg::TIME_BITS-1:0]       deadline_ff;
   logic [cts_pkg::TIME_BITS-1:0]       frame_end_ff;

   // Per-item results and window walk.
   logic                                switched_ff;
   logic [cts_pkg::TIME_BITS-1:0]       wstart_ff;
   logic                                wfound_ff;
   logic [cts_pkg::SLOT_BITS-1:0]       scan_ff;
   logic [cts_pkg::SLOT_BITS-1:0]       eval_ff;
   logic [cts_pkg::TIME_BITS-1:0]       offset_ff;

   // Result register.
   logic [cts_pkg::OWNER_BITS-1:0]      res_owner_ff;
   logic                                res_switched_ff;
   logic [cts_pkg::SLOT_BITS-1:0]       res_slot_ff;
   logic [cts_pkg::TIME_BITS-1:0]       res_deadline_ff;
   logic [cts_pkg::TIME_BITS-1:0]       res_wstart_ff;
   logic                                res_wfound_ff;

   logic [cts_pkg::SLOT_BITS-1:0]       cur_next;
   logic                                cur_wraps;
   logic [cts_pkg::SLOT_BITS-1:0]       scan_next;
   logic [cts_pkg::TIME_BITS-1:0]       rd_duration;

   assign cur_next    = cts_pkg::next_slot(cur_slot_ff, slot_count_used);
   assign cur_wraps   = cts_pkg::slot_wraps(cur_slot_ff, slot_count_used);
   assign scan_next   = cts_pkg::next_slot(scan_ff, slot_count_used);
   assign rd_duration = cts_pkg::TIME_BITS'(rd_entry_ff.duration);

   // Status back to the controller.
   always_comb begin
      status.op        = op_ff;
      status.tick_due  = (deadline_ff <= now_ff);
      status.walk_hit  = rd_entry_ff.periodic && (rd_entry_ff.owner == cur_owner_ff);
      status.walk_last = (eval_ff ==
                          cts_pkg::SLOT_BITS'(slot_count_used - cts_pkg::COUNT_BITS'(1)));
   end

   // Table read address: slot 0 on restart, the following slot on tick and walk.
   always_comb begin
      rd_en   = cmd.restart_start || cmd.tick_start || cmd.walk_start || cmd.walk_step;
      rd_addr = '0;
      priority if (cmd.tick_start || cmd.walk_start) begin
         rd_addr = cur_next;
      end else if (cmd.walk_step) begin
         rd_addr = scan_next;
      end else begin
         rd_addr = '0;
      end
   end

   // Input capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff                <= in_operation;
         now_ff               <= in_now;
         index_ff             <= in_slot_index;
         wr_entry_ff.duration <= in_slot_length;
         wr_entry_ff.owner    <= in_slot_owner;
         wr_entry_ff.periodic <= in_slot_periodic;
      end
   end

   // Slot table: every 5-bit index lies inside the table, so writes always land.
   always_ff @(posedge clock) begin
      if (cmd.table_write) begin
         table_mem[index_ff] <= wr_entry_ff;
      end
      if (rd_en) begin
         rd_entry_ff <= table_mem[rd_addr];
      end
   end

   // Schedule state updates on restart and tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_slot_ff  <= '0;
         cur_owner_ff <= '0;
         deadline_ff  <= '0;
         frame_end_ff <= '0;
      end else begin
         if (cmd.restart_start) begin
            frame_end_ff <= now_ff + cts_pkg::TIME_BITS'(frame_length);
         end
         if (cmd.tick_start) begin
            cur_slot_ff <= cur_next;
            if (cur_wraps) begin
               frame_end_ff <= frame_end_ff + cts_pkg::TIME_BITS'(frame_length);
            end
         end
         if (cmd.restart_apply) begin
            cur_slot_ff  <= '0;
            deadline_ff  <= now_ff + rd_duration;
            cur_owner_ff <= rd_entry_ff.owner;
         end
         if (cmd.tick_apply) begin
            deadline_ff  <= deadline_ff + rd_duration;
            cur_owner_ff <= rd_entry_ff.owner;
         end
      end
   end

   // Per-item flags and the periodic window walk, one table entry a cycle.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         switched_ff <= 1'b0;
         wstart_ff   <= '0;
         wfound_ff   <= 1'b0;
      end
      if (cmd.restart_apply || cmd.tick_apply) begin
         switched_ff <= (rd_entry_ff.owner != cur_owner_ff);
      end
      if (cmd.walk_start) begin
         scan_ff   <= cur_next;
         eval_ff   <= '0;
         offset_ff <= deadline_ff;
      end
      if (cmd.walk_step) begin
         if (status.walk_hit) begin
            wstart_ff <= offset_ff;
            wfound_ff <= 1'b1;
         end else begin
            offset_ff <= offset_ff + rd_duration;
            scan_ff   <= scan_next;
            eval_ff   <= eval_ff + cts_pkg::SLOT_BITS'(1);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         res_owner_ff    <= cur_owner_ff;
         res_switched_ff <= switched_ff;
         res_slot_ff     <= cur_slot_ff;
         res_deadline_ff <= deadline_ff;
         res_wstart_ff   <= wstart_ff;
         res_wfound_ff   <= wfound_ff;
      end
   end

   assign out_owner        = res_owner_ff;
   assign out_switched     = res_switched_ff;
   assign out_slot         = res_slot_ff;
   assign out_deadline     = res_deadline_ff;
   assign out_window_start = res_wstart_ff;
   assign out_window_found = res_wfound_ff;

endmodule

>>> hw/rtl/cyclic_time_slot_scheduler_top.sv
// A write or a tick not yet due passes capture and decode, then loads the result register;
// a restart or a due tick adds an apply step (one slot table read), and a query walks k slots
// (one table entry a cycle, k at most the number of slots in use) before its result load.
// One item in work at a time; a new beat waits for the result load, delayed while the
// result beat is stalled. Reset clears the schedule to slot 0, owner 0, deadline 0, sets
// slot_count to 1 and frame_length to 0; the slot table holds no defined value until written.
module cyclic_time_slot_scheduler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // tdata: now[63:0], slot_index[68:64], slot_length[100:69], slot_owner[108:101],
   // slot_periodic[109], zero fill[111:110]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cts_pkg::IN_DATA_BITS-1:0]     req_tdata,
   // tuser: operation[1:0]
   input  logic [cts_pkg::IN_OP_BITS-1:0]       req_tuser,
   // tdata: owner[7:0], switched[8], slot[13:9], deadline[77:14], window_start[141:78],
   // window_found[142], zero fill[143]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cts_pkg::OUT_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cts_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [cts_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [cts_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   logic [cts_pkg::COUNT_BITS-1:0]  slot_count_ff;
   logic [cts_pkg::DUR_BITS-1:0]    frame_length_ff;
   logic                            csr_write;

   cts_pkg::cmd_type                cmd;
   cts_pkg::status_type             status;

   logic [cts_pkg::OWNER_BITS-1:0]  out_owner;
   logic                            out_switched;
   logic [cts_pkg::SLOT_BITS-1:0]   out_slot;
   logic [cts_pkg::TIME_BITS-1:0]   out_deadline;
   logic [cts_pkg::TIME_BITS-1:0]   out_window_start;
   logic                            out_window_found;

   // Configuration registers, decoded by word address.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff   <= cts_pkg::SLOT_COUNT_RESET;
         frame_length_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2] == cts_pkg::REG_SLOT_COUNT) begin
            slot_count_ff <= csr_pwdata[cts_pkg::COUNT_BITS-1:0];
         end else begin
            frame_length_ff <= csr_pwdata[cts_pkg::DUR_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == cts_pkg::REG_FRAME_LENGTH) begin
         csr_prdata = cts_pkg::CSR_DATA_BITS'(frame_length_ff);
      end else begin
         csr_prdata = cts_pkg::CSR_DATA_BITS'(slot_count_ff);
      end
   end

   cts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .in_operation     (cts_pkg::op_type'(req_tuser)),
      .in_now           (req_tdata[63:0]),
      .in_slot_index    (req_tdata[68:64]),
      .in_slot_length   (req_tdata[100:69]),
      .in_slot_owner    (req_tdata[108:101]),
      .in_slot_periodic (req_tdata[109]),
      .slot_count_used  (cts_pkg::used_count(slot_count_ff)),
      .frame_length     (frame_length_ff),
      .cmd              (cmd),
      .status           (status),
      .out_owner        (out_owner),
      .out_switched     (out_switched),
      .out_slot         (out_slot),
      .out_deadline     (out_deadline),
      .out_window_start (out_window_start),
      .out_window_found (out_window_found)
   );

   // Result beat packing.
   assign rsp_tdata = {1'b0, out_window_found, out_window_start, out_deadline,
                       out_slot, out_switched, out_owner};

endmodule

>>> hw/rtl/cts_checker.sv
// Port-level checker for the slot scheduler, bound to the top level.
module cts_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [cts_pkg::OUT_DATA_BITS-1:0]    rsp_tdata
);

   // A stalled result beat stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // Items are worked one at a time: no second beat right after an accepted one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while the previous item is in work");

   // A found window only comes from a query, which never reports an owner switch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[142] |-> !rsp_tdata[8])
      else $error("window found together with an owner switch");

   // No result beat right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind cyclic_time_slot_scheduler_top cts_checker u_cts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
